/* hw/rtl/raft_log_store_unit_defines.svh */
// Assertion macros for the log store RTL.
// Used by rls_back to check its own control logic; no other dependencies.
`ifndef RAFT_LOG_STORE_UNIT_DEFINES_SVH
`define RAFT_LOG_STORE_UNIT_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define RLS_ASSERT_NOW(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define RLS_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* hw/rtl/rls_pkg.sv */
// Shared types and constants of the log store.
// No dependencies; used by every RTL module of the block.
package rls_pkg;

    localparam int LOG_DEPTH_DEF = 1024;
    localparam int TERM_BITS_DEF = 32;

    localparam int IDX_FIELD_W = 10;   // width of index fields on the ports
    localparam int SLOT_W      = 11;   // holds prev_index + 1 + batch_offset
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [1:0] {
        KIND_APPEND    = 2'd0,
        KIND_REPLICATE = 2'd1,
        KIND_READ      = 2'd2,
        KIND_TRUNCATE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NO_CHANGE = 2'd1,
        ST_FULL      = 2'd2,
        ST_GAP       = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        BK_FETCH = 1'b0,
        BK_EXEC  = 1'b1
    } back_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [9:0]  prev_index;
        logic [9:0]  batch_offset;
        logic [9:0]  target_index;
        logic [31:0] entry_term;
        logic [31:0] entry_payload;
        logic [31:0] query_term;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [9:0]  written_index;
        logic        found;
        logic        term_match;
        logic [31:0] read_term;
        logic [31:0] read_payload;
        logic [9:0]  last_index;
        logic [31:0] last_term;
    } rsp_t;

    // Classified operation passed from the front end to the back end.
    typedef struct packed {
        kind_t              kind;
        logic [SLOT_W-1:0]  slot;      // slot the operation is about
        logic [SLOT_W-1:0]  rd_slot;   // slot whose term the back end reads
        logic [31:0]        entry_term;
        logic [31:0]        entry_payload;
        logic [31:0]        query_term;
    } op_t;

endpackage

/* hw/rtl/raft_log_store_unit.sv */
// Top level of the consensus log store: front end, operation queue, back end.
// Depends on rls_pkg, rls_front, rls_queue and rls_back.
//
//   channel   direction  handshake               word
//   request   in         req_valid / req_ready   req (rls_pkg::req_t)
//   response  out        rsp_valid / rsp_ready   rsp (rls_pkg::rsp_t)
//
// The back end handles one word at a time: it reads the addressed slot of the
// term and payload memories in the fetch state, then updates the tail and
// writes the memories in the execute state, where the response is registered.
// A two-entry queue lets requests be taken while the back end works; a held
// response stalls only the execute state.
// After reset the log holds only the sentinel; no clearing pass is needed.
module raft_log_store_unit
#(
    parameter int LOG_DEPTH = rls_pkg::LOG_DEPTH_DEF,
    parameter int TERM_BITS = rls_pkg::TERM_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  rls_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output rls_pkg::rsp_t rsp
);

    logic         fr_valid;
    logic         fr_ready;
    rls_pkg::op_t fr_op;
    logic         q_valid;
    logic         q_pop;
    rls_pkg::op_t q_op;

    rls_front u_front
    (
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .op_valid  (fr_valid),
        .op_ready  (fr_ready),
        .op        (fr_op)
    );

    rls_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_op    (fr_op),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_op     (q_op)
    );

    rls_back
    #(
        .LOG_DEPTH (LOG_DEPTH),
        .TERM_BITS (TERM_BITS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (q_valid),
        .pop       (q_pop),
        .op        (q_op),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

/* hw/rtl/rls_front.sv */
// Front end: accepts request words and turns them into classified operations.
// Depends on rls_pkg.
module rls_front
(
    input  logic          req_valid,
    output logic          req_ready,
    input  rls_pkg::req_t req,
    output logic          op_valid,
    input  logic          op_ready,
    output rls_pkg::op_t  op
);

    logic [rls_pkg::SLOT_W-1:0] target_ext;
    logic [rls_pkg::SLOT_W-1:0] repl_slot;

    assign target_ext = rls_pkg::SLOT_W'(req.target_index);
    assign repl_slot  = rls_pkg::SLOT_W'(req.prev_index)
                      + rls_pkg::SLOT_W'(req.batch_offset)
                      + rls_pkg::SLOT_W'(1);

    assign op_valid  = req_valid;
    assign req_ready = op_ready;

    always_comb
    begin
        op.kind          = req.kind;
        op.entry_term    = req.entry_term;
        op.entry_payload = req.entry_payload;
        op.query_term    = req.query_term;
        op.slot          = target_ext;
        op.rd_slot       = target_ext;
        case (req.kind)
            rls_pkg::KIND_REPLICATE:
            begin
                op.slot    = repl_slot;
                op.rd_slot = repl_slot;
            end
            rls_pkg::KIND_TRUNCATE:
            begin
                // The new newest term is the one just below the cut.
                if (target_ext != '0)
                begin
                    op.rd_slot = target_ext - rls_pkg::SLOT_W'(1);
                end
                else
                begin
                    op.rd_slot = '0;
                end
            end
            default:
            begin
                op.slot    = target_ext;
                op.rd_slot = target_ext;
            end
        endcase
    end

endmodule

/* hw/rtl/rls_queue.sv */
// Two-entry queue of classified operations between front and back end.
// Depends on rls_pkg.
module rls_queue
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  rls_pkg::op_t push_op,
    output logic         pop_valid,
    input  logic         pop,
    output rls_pkg::op_t pop_op
);

    rls_pkg::op_t                entry_reg [rls_pkg::QDEPTH];
    logic [rls_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [rls_pkg::QPTR_W-1:0]  wr_ptr_next;
    logic [rls_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [rls_pkg::QPTR_W-1:0]  rd_ptr_next;
    logic [rls_pkg::QCNT_W-1:0]  count_reg;
    logic [rls_pkg::QCNT_W-1:0]  count_next;
    logic                        do_push;
    logic                        do_pop;

    assign push_ready = (count_reg != rls_pkg::QCNT_W'(rls_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + rls_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + rls_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + rls_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - rls_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

/* hw/rtl/rls_back.sv */
// Back end: owns the term and payload memories and the tail state; executes
// one operation at a time, reading in fetch, writing in execute. Depends on
// rls_pkg and the assertion macros in raft_log_store_unit_defines.svh.
`include "raft_log_store_unit_defines.svh"

module rls_back
#(
    parameter int LOG_DEPTH = rls_pkg::LOG_DEPTH_DEF,
    parameter int TERM_BITS = rls_pkg::TERM_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          op_valid,
    output logic          pop,
    input  rls_pkg::op_t  op,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output rls_pkg::rsp_t rsp
);

    localparam int IDX_W  = $clog2(LOG_DEPTH);
    localparam int SIZE_W = $clog2(LOG_DEPTH + 1);
    localparam int CMP_W  = (SIZE_W > rls_pkg::SLOT_W) ? SIZE_W : rls_pkg::SLOT_W;

    logic [TERM_BITS-1:0] term_mem [LOG_DEPTH];
    logic [31:0]          payload_mem [LOG_DEPTH];

    rls_pkg::back_state_t state_reg;
    rls_pkg::back_state_t state_next;
    rls_pkg::op_t         op_reg;
    logic                 rd_zero_reg;
    logic [TERM_BITS-1:0] term_rd_reg;
    logic [31:0]          payload_rd_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [SIZE_W-1:0]    size_next;
    logic [TERM_BITS-1:0] newest_reg;
    logic [TERM_BITS-1:0] newest_next;
    logic                 out_valid_reg;
    rls_pkg::rsp_t        out_data_reg;
    rls_pkg::rsp_t        rsp_next;

    logic                 complete;
    logic                 wr_en;
    logic                 wr_req;
    logic [IDX_W-1:0]     wr_addr;
    logic [IDX_W-1:0]     rd_addr;

    logic [TERM_BITS-1:0] eterm;
    logic [TERM_BITS-1:0] qterm;
    logic [TERM_BITS-1:0] rterm;
    logic [CMP_W-1:0]     slot_ext;
    logic [CMP_W-1:0]     size_ext;
    logic [CMP_W-1:0]     size_next_ext;
    logic [CMP_W-1:0]     last_ext;
    logic                 is_full;

    assign rd_addr  = IDX_W'(op.rd_slot);
    assign eterm    = TERM_BITS'(op_reg.entry_term);
    assign qterm    = TERM_BITS'(op_reg.query_term);
    // Slot zero is the sentinel and is never written, so it reads as term 0.
    assign rterm    = rd_zero_reg ? '0 : term_rd_reg;
    assign slot_ext = CMP_W'(op_reg.slot);
    assign size_ext = CMP_W'(size_reg);
    assign is_full  = (size_reg == SIZE_W'(LOG_DEPTH));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rls_pkg::BK_FETCH:
            begin
                if (op_valid)
                begin
                    state_next = rls_pkg::BK_EXEC;
                end
            end
            rls_pkg::BK_EXEC:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    state_next = rls_pkg::BK_FETCH;
                end
            end
            default:
            begin
                state_next = rls_pkg::BK_FETCH;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        pop      = 1'b0;
        complete = 1'b0;
        case (state_reg)
            rls_pkg::BK_FETCH:
            begin
                pop = op_valid;
            end
            rls_pkg::BK_EXEC:
            begin
                complete = !out_valid_reg || rsp_ready;
            end
            default:
            begin
                pop      = 1'b0;
                complete = 1'b0;
            end
        endcase
    end

    // Execution of the held operation against the tail state.
    always_comb
    begin
        wr_req      = 1'b0;
        wr_addr     = IDX_W'(size_reg);
        size_next   = size_reg;
        newest_next = newest_reg;
        rsp_next    = '0;
        rsp_next.status = rls_pkg::ST_DONE;
        case (op_reg.kind)
            rls_pkg::KIND_APPEND:
            begin
                if (is_full)
                begin
                    rsp_next.status = rls_pkg::ST_FULL;
                end
                else
                begin
                    wr_req                 = 1'b1;
                    size_next              = SIZE_W'(size_ext + CMP_W'(1));
                    newest_next            = eterm;
                    rsp_next.written_index = size_ext[rls_pkg::IDX_FIELD_W-1:0];
                end
            end
            rls_pkg::KIND_REPLICATE:
            begin
                if (slot_ext > size_ext)
                begin
                    rsp_next.status = rls_pkg::ST_GAP;
                end
                else if (slot_ext == size_ext)
                begin
                    if (is_full)
                    begin
                        rsp_next.status = rls_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr_req                 = 1'b1;
                        size_next              = SIZE_W'(size_ext + CMP_W'(1));
                        newest_next            = eterm;
                        rsp_next.written_index = slot_ext[rls_pkg::IDX_FIELD_W-1:0];
                    end
                end
                else if (rterm != eterm)
                begin
                    // A conflicting term cuts the log here before the write.
                    wr_req                 = 1'b1;
                    wr_addr                = IDX_W'(slot_ext);
                    size_next              = SIZE_W'(slot_ext + CMP_W'(1));
                    newest_next            = eterm;
                    rsp_next.written_index = slot_ext[rls_pkg::IDX_FIELD_W-1:0];
                end
                else
                begin
                    rsp_next.status        = rls_pkg::ST_NO_CHANGE;
                    rsp_next.written_index = slot_ext[rls_pkg::IDX_FIELD_W-1:0];
                end
            end
            rls_pkg::KIND_READ:
            begin
                if (slot_ext < size_ext)
                begin
                    rsp_next.read_term  = 32'(rterm);
                    rsp_next.term_match = (rterm == qterm);
                    if (slot_ext != '0)
                    begin
                        rsp_next.found        = 1'b1;
                        rsp_next.read_payload = payload_rd_reg;
                    end
                end
            end
            rls_pkg::KIND_TRUNCATE:
            begin
                if ((slot_ext != '0) && (slot_ext < size_ext))
                begin
                    size_next   = SIZE_W'(slot_ext);
                    newest_next = rterm;
                end
                else
                begin
                    rsp_next.status = rls_pkg::ST_NO_CHANGE;
                end
            end
            default:
            begin
                rsp_next.status = rls_pkg::ST_DONE;
            end
        endcase
        rsp_next.last_index = last_ext[rls_pkg::IDX_FIELD_W-1:0];
        rsp_next.last_term  = 32'(newest_next);
    end

    assign size_next_ext = CMP_W'(size_next);
    assign last_ext      = size_next_ext - CMP_W'(1);
    assign wr_en         = wr_req && complete;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rls_pkg::BK_FETCH;
            size_reg      <= SIZE_W'(1);
            newest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (complete)
            begin
                size_reg      <= size_next;
                newest_reg    <= newest_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg      <= op;
            rd_zero_reg <= (op.rd_slot == '0);
        end
        if (complete)
        begin
            out_data_reg <= rsp_next;
        end
    end

    // Memories: one read port in the fetch cycle, one write port in the
    // execute cycle, so the two never meet at the same edge.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            term_rd_reg    <= term_mem[rd_addr];
            payload_rd_reg <= payload_mem[rd_addr];
        end
        if (wr_en)
        begin
            term_mem[wr_addr]    <= eterm;
            payload_mem[wr_addr] <= op_reg.entry_payload;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    `RLS_ASSERT_NOW(a_size_range, 1'b1, (size_reg != '0) && (size_reg <= SIZE_W'(LOG_DEPTH)), "log size out of range")
    `RLS_ASSERT_NEXT(a_pop_to_exec, pop, state_reg == rls_pkg::BK_EXEC, "pop did not start execution")
    `RLS_ASSERT_NOW(a_write_on_complete, wr_en, complete && (state_reg == rls_pkg::BK_EXEC), "memory write outside completion")
    `RLS_ASSERT_NEXT(a_complete_shows_word, complete, out_valid_reg, "completed word not presented")

endmodule
